[rtl/core/rdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the response deframer and crc check unit.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // input actions
  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_CLOSE  = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_SUCCESS  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  // work handed from the front end to the back end
  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_FRAME,
    JOB_ARM,
    JOB_CANCEL,
    JOB_CLOSE
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] id;      // frame id, or request id for an arm
    logic [31:0] value;
    logic        crc_ok;
    logic        boot;
  } job_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic        boot;
  } result_t;

  // framing bytes and frame header
  localparam logic [7:0]  StartByte   = 8'h2B;
  localparam logic [7:0]  EscapeByte  = 8'h2D;
  localparam logic [7:0]  RespCommand = 8'd5;
  localparam logic [7:0]  RespLength  = 8'd8;
  localparam logic [31:0] MagicWord   = 32'h50F7_05AB;

  // crc-16/ccitt-false
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // byte positions inside a frame
  localparam logic [3:0] IdxCmd      = 4'd0;
  localparam logic [3:0] IdxLen      = 4'd1;
  localparam logic [3:0] IdxIdFirst  = 4'd2;
  localparam logic [3:0] IdxIdLast   = 4'd5;
  localparam logic [3:0] IdxValFirst = 4'd6;
  localparam logic [3:0] IdxValLast  = 4'd9;
  localparam logic [3:0] IdxCrcHi    = 4'd10;
  localparam logic [3:0] IdxCrcLo    = 4'd11;

endpackage
`default_nettype wire

[rtl/core/rdc_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_fifo
// Small register queue with push/full and pop/empty, head shown while not empty.
// ----------------------------------------------------------------------------
module rdc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : AddrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : AddrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[rtl/core/rdc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_front
// Deframer front end: start hunt, escape handling, header check, running crc,
// id/value capture and magic word window. Emits one job per accepted item.
// ----------------------------------------------------------------------------
module rdc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        request_id_i,
  input  logic               job_full_i,
  output logic               job_push_o,
  output rdc_pkg::job_t      job_o
);

  import rdc_pkg::*;

  logic        hunt_q, hunt_d;
  logic [7:0]  prev_q, prev_d;
  logic [31:0] win_q, win_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [31:0] id_q, id_d;
  logic [31:0] val_q, val_d;
  logic        accept, esc, store;
  logic [15:0] crc_seed, crc_next;

  // byte-wise crc-16 update, msb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in;
    for (int k = 7; k >= 0; k--) begin
      if (b[k] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign accept   = push_i && !job_full_i;
  assign esc      = (prev_q == EscapeByte);
  assign crc_seed = (cnt_q == IdxCmd) ? CrcInit : crc_q;
  assign crc_next = crc_update(crc_seed, data_byte_i);

  // classify the item and advance the deframer
  always_comb begin
    hunt_d     = hunt_q;
    prev_d     = prev_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    id_d       = id_q;
    val_d      = val_q;
    store      = 1'b0;
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.kind = JOB_NONE;
    if (accept) begin
      job_push_o = 1'b1;
      job_o.boot = (win_q == MagicWord);
      case (action_e'(action_i))
        ACT_BYTE: begin
          win_d  = {win_q[23:0], data_byte_i};
          prev_d = data_byte_i;
          if (hunt_q) begin
            if (data_byte_i == StartByte && !esc) begin
              hunt_d = 1'b0;
            end
          end else if (data_byte_i == StartByte) begin
            if (esc) begin
              store = 1'b1;
            end else begin
              cnt_d = '0;
            end
          end else if (data_byte_i == EscapeByte) begin
            store = esc;
          end else begin
            store = 1'b1;
          end
          // place the stored byte by its frame position
          if (store) begin
            cnt_d = 4'(cnt_q + 4'd1);
            if (cnt_q == IdxCmd) begin
              crc_d = crc_next;
              if (data_byte_i != RespCommand) begin
                hunt_d = 1'b1;
                cnt_d  = '0;
              end
            end else if (cnt_q == IdxLen) begin
              crc_d = crc_next;
              if (data_byte_i != RespLength) begin
                hunt_d = 1'b1;
                cnt_d  = '0;
              end
            end else if (cnt_q inside {[IdxIdFirst:IdxIdLast]}) begin
              crc_d = crc_next;
              id_d  = {id_q[23:0], data_byte_i};
            end else if (cnt_q inside {[IdxValFirst:IdxValLast]}) begin
              crc_d = crc_next;
              val_d = {val_q[23:0], data_byte_i};
            end else if (cnt_q == IdxCrcHi) begin
              crc_hi_d = data_byte_i;
            end else begin
              // last crc byte closes the frame
              hunt_d       = 1'b1;
              cnt_d        = '0;
              job_o.kind   = JOB_FRAME;
              job_o.id     = id_q;
              job_o.value  = val_q;
              job_o.crc_ok = (crc_q == {crc_hi_q, data_byte_i});
            end
          end
          job_o.boot = (win_d == MagicWord);
        end
        ACT_ARM: begin
          job_o.kind = JOB_ARM;
          job_o.id   = request_id_i;
        end
        ACT_CANCEL: begin
          job_o.kind = JOB_CANCEL;
        end
        ACT_CLOSE: begin
          job_o.kind = JOB_CLOSE;
          job_o.boot = 1'b0;
          prev_d     = '0;
          win_d      = '0;
          hunt_d     = 1'b1;
          cnt_d      = '0;
        end
        default: begin
          job_o.kind = JOB_NONE;
        end
      endcase
    end
  end

  // deframer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q <= 1'b1;
      prev_q <= '0;
      win_q  <= '0;
      cnt_q  <= '0;
    end else begin
      hunt_q <= hunt_d;
      prev_q <= prev_d;
      win_q  <= win_d;
      cnt_q  <= cnt_d;
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    crc_q    <= crc_d;
    crc_hi_q <= crc_hi_d;
    id_q     <= id_d;
    val_q    <= val_d;
  end

endmodule
`default_nettype wire

[rtl/core/rdc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_back
// Request tracking back end: holds the armed id, matches complete frames and
// turns each job into one result item.
// ----------------------------------------------------------------------------
module rdc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  rdc_pkg::job_t    job_i,
  output logic             job_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output rdc_pkg::result_t res_o
);

  import rdc_pkg::*;

  logic        armed_q, armed_d;
  logic [31:0] armed_id_q, armed_id_d;

  assign job_pop_o  = job_valid_i && !res_full_i;
  assign res_push_o = job_pop_o;

  // resolve one job
  always_comb begin
    armed_d      = armed_q;
    armed_id_d   = armed_id_q;
    res_o.status = ST_NONE;
    res_o.value  = '0;
    res_o.boot   = job_i.boot;
    if (job_pop_o) begin
      case (job_i.kind)
        JOB_FRAME: begin
          if (!armed_q || armed_id_q != job_i.id) begin
            res_o.status = ST_IGNORED;
          end else begin
            armed_d = 1'b0;
            if (job_i.crc_ok) begin
              res_o.status = ST_SUCCESS;
              res_o.value  = job_i.value;
            end else begin
              res_o.status = ST_MISMATCH;
            end
          end
        end
        JOB_ARM: begin
          armed_d    = 1'b1;
          armed_id_d = job_i.id;
        end
        JOB_CANCEL: begin
          armed_d = 1'b0;
        end
        JOB_CLOSE: begin
          armed_d    = 1'b0;
          armed_id_d = '0;
        end
        default: begin
          armed_d = armed_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      armed_id_q <= '0;
    end else begin
      armed_q    <= armed_d;
      armed_id_q <= armed_id_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/response_deframer_crc_check_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// response_deframer_crc_check_unit
// Escaped-frame response deframer with crc-16/ccitt-false check.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item. One item is taken per
// clock cycle while the job queue has room; a result passes the job queue and
// the back end into the output queue, where it can be taken. The front end
// updates the crc by one whole byte per cycle and the back end resolves one
// job per cycle, each while its next queue has room; a JobDepth-entry queue
// between them and a ResDepth-entry output queue let either side stall while
// the other keeps going. Reset leaves both queues empty and nothing armed.
module response_deframer_crc_check_unit #(
  parameter int JobDepth = 2,
  parameter int ResDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] request_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] value_bits_o,
  output logic        bootloader_seen_o
);

  import rdc_pkg::*;

  job_t    job_in, job_out;
  result_t res_in, res_out;
  logic    job_push, job_full, job_empty, job_pop;
  logic    res_push, res_full;

  // front end: deframing and classification
  rdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .request_id_i(request_id_i),
    .job_full_i  (job_full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  assign full = job_full;

  // queue between front and back
  rdc_fifo #(
    .Width($bits(job_t)),
    .Depth(JobDepth)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_out),
    .empty_o(job_empty)
  );

  // back end: request matching
  rdc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // output queue
  rdc_fifo #(
    .Width($bits(result_t)),
    .Depth(ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign status_o          = res_out.status;
  assign value_bits_o      = res_out.value;
  assign bootloader_seen_o = res_out.boot;

endmodule
`default_nettype wire

[rtl/core/rdc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the response deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [1:0]  action_i,
  input logic [7:0]  data_byte_i,
  input logic [31:0] request_id_i,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic [31:0] value_bits_o,
  input logic        bootloader_seen_o
);

  import rdc_pkg::*;

  // queues come out of reset empty and open
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty && !full)
    else $error("queues not cleared in reset");

  // value is only given with a success
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != ST_SUCCESS |-> value_bits_o == '0)
    else $error("value shown without success");

  // an item taken on an empty output shows up as a result once it has passed the back end
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && empty |-> ##2 !empty)
    else $error("result missing after item");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(value_bits_o)
                       && $stable(bootloader_seen_o))
    else $error("waiting result changed");

endmodule

bind response_deframer_crc_check_unit rdc_checker u_rdc_checker (.*);
`default_nettype wire
